FILE: src/vba_pkg.sv
package vba_pkg;

  localparam int MaxElements = 1024;
  localparam int NumBuffers  = 4;
  localparam int DataWidth   = 32;
  localparam int IdxW        = 10;
  localparam int BufW        = 2;
  localparam int AddrW       = BufW + IdxW;
  localparam int CountW      = 11;
  localparam int BufCountW   = 3;
  localparam int CfgW        = 11;
  localparam int ItemW       = 119;
  localparam int UserW       = 2;
  localparam int InW         = 120;
  localparam int OutW        = 40;
  localparam int OpW         = 35;
  localparam int LoW         = 49;
  localparam int HiW         = 51;
  localparam int WideW       = 56;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_EXEC = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OP_COPY  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_SCALE = 3'd4,
    OP_AXPY  = 3'd5,
    OP_CLAMP = 3'd6,
    OP_LAP   = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_DA   = 3'd1,
    ST_BAD_B    = 3'd2,
    ST_BOUNDS   = 3'd3,
    ST_BAD_ADDR = 3'd4
  } status_t;

  typedef enum logic {
    CFG_ELEMENT_COUNT = 1'b0,
    CFG_BUFFER_COUNT  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] load_value;
    logic [IdxW-1:0]    element_index;
    logic [BufW-1:0]    buffer_sel;
    logic signed [31:0] scalar_second;
    logic signed [31:0] scalar_first;
    logic [BufW-1:0]    src_b_buf;
    logic [BufW-1:0]    src_a_buf;
    logic [BufW-1:0]    dest_buf;
    opcode_t            opcode;
    func_t              func;
  } item_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic rd_a;
    logic rd_x;
    logic rd_y;
    logic cap;
    logic mul_lo;
    logic mul_hi;
    logic wr_elem;
    logic present;
  } cmd_t;

  typedef struct packed {
    logic exec_go;
    logic last;
    logic out_free;
  } stat_t;

endpackage

FILE: src/vector_buffer_alu.sv
// Bank of four vector buffers of up to 1024 Q16.16 elements, one 4096-word memory with
// one read and one write port, and an element ALU. Each input transfer yields one output
// transfer. Loads, reads, no-ops and rejected executes go from decode straight to the
// output; an execute walks each element in turn (three memory reads of source a, b or
// neighbors, an operand capture, a two-step multiply and the write back). A result not
// yet taken holds the block in its final state. The memory powers up undefined.
module vector_buffer_alu (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // opcode, dest_buf, src_a_buf, src_b_buf, scalar_first, scalar_second,
  // buffer_sel, element_index, load_value
  input  logic [vba_pkg::InW-1:0]   s_tdata,
  // func
  input  logic [vba_pkg::UserW-1:0] s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // read_value, status, saturated
  output logic [vba_pkg::OutW-1:0]  m_tdata,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [vba_pkg::CfgW-1:0]  cfg_data
);
  import vba_pkg::*;

  cmd_t  cmd;
  stat_t st;

  vba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  vba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: src/vba_ctrl.sv
module vba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  vba_pkg::stat_t st,
  output vba_pkg::cmd_t  cmd
);
  import vba_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_RA     = 11'b000_0000_0100,
    S_RX     = 11'b000_0000_1000,
    S_RY     = 11'b000_0001_0000,
    S_CAP    = 11'b000_0010_0000,
    S_ML     = 11'b000_0100_0000,
    S_MH     = 11'b000_1000_0000,
    S_WR     = 11'b001_0000_0000,
    S_DONE   = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = st.exec_go ? S_RA : S_DONE;
      end
      S_RA: begin
        cmd.rd_a = 1'b1;
        state_next = S_RX;
      end
      S_RX: begin
        cmd.rd_x = 1'b1;
        state_next = S_RY;
      end
      S_RY: begin
        cmd.rd_y = 1'b1;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.cap = 1'b1;
        state_next = S_ML;
      end
      S_ML: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MH;
      end
      S_MH: begin
        cmd.mul_hi = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_elem = 1'b1;
        state_next = st.last ? S_DONE : S_RA;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.present = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/vba_dp.sv
module vba_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [vba_pkg::InW-1:0]    s_tdata,
  input  logic [vba_pkg::UserW-1:0]  s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [vba_pkg::OutW-1:0]   m_tdata,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [vba_pkg::CfgW-1:0]   cfg_data,
  input  vba_pkg::cmd_t              cmd,
  output vba_pkg::stat_t             st
);
  import vba_pkg::*;

  logic [DataWidth-1:0] mem [NumBuffers*MaxElements];
  logic [DataWidth-1:0] rdata;
  logic                 re;
  logic                 we;
  logic [AddrW-1:0]     raddr;
  logic [AddrW-1:0]     waddr;
  logic [DataWidth-1:0] wdata;

  item_t                item;
  logic [CountW-1:0]    elem_count;
  logic [BufCountW-1:0] buf_count;
  logic [CountW-1:0]    n;
  logic [BufCountW-1:0] nb;
  logic                 uses_b;
  status_t              status_dec;
  status_t              res_status;
  logic                 is_read;
  logic                 sat_flag;
  logic [IdxW-1:0]      i;
  logic [IdxW-1:0]      left;
  logic [IdxW-1:0]      right;
  logic                 last;

  logic signed [31:0]    av;
  logic signed [31:0]    xv;
  logic signed [OpW-1:0] xop;
  logic signed [31:0]    kop;
  logic signed [OpW-1:0] lap_sum;
  logic signed [LoW-1:0] plo;
  logic signed [HiW-1:0] phi;
  logic signed [WideW-1:0] prod;
  logic signed [WideW-1:0] w;
  logic                  ovf_hi;
  logic                  ovf_lo;
  logic [DataWidth-1:0]  elem_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= CountW'(MaxElements);
      buf_count  <= BufCountW'(NumBuffers);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ELEMENT_COUNT: elem_count <= cfg_data;
        CFG_BUFFER_COUNT:  buf_count  <= cfg_data[BufCountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (elem_count == '0) begin
      n = CountW'(1);
    end else if (elem_count > CountW'(MaxElements)) begin
      n = CountW'(MaxElements);
    end else begin
      n = elem_count;
    end
    if (buf_count == '0) begin
      nb = BufCountW'(1);
    end else if (buf_count > BufCountW'(NumBuffers)) begin
      nb = BufCountW'(NumBuffers);
    end else begin
      nb = buf_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= item_t'({s_tdata[ItemW-UserW-1:0], s_tuser});
    end
  end

  assign uses_b = (item.opcode == OP_ADD) || (item.opcode == OP_SUB) ||
                  (item.opcode == OP_MUL) || (item.opcode == OP_AXPY);

  always_comb begin
    status_dec = ST_OK;
    unique case (item.func) inside
      FUNC_LOAD, FUNC_READ: begin
        if ({1'b0, item.buffer_sel} >= nb || {1'b0, item.element_index} >= n) begin
          status_dec = ST_BAD_ADDR;
        end
      end
      FUNC_EXEC: begin
        if ({1'b0, item.dest_buf} >= nb || {1'b0, item.src_a_buf} >= nb) begin
          status_dec = ST_BAD_DA;
        end else if (uses_b && {1'b0, item.src_b_buf} >= nb) begin
          status_dec = ST_BAD_B;
        end else if (item.opcode == OP_CLAMP && item.scalar_first > item.scalar_second) begin
          status_dec = ST_BOUNDS;
        end
      end
      default: status_dec = ST_OK;
    endcase
  end

  assign last  = ({1'b0, i} == n - CountW'(1));
  assign left  = (i == '0) ? IdxW'(n - CountW'(1)) : i - IdxW'(1);
  assign right = last ? '0 : i + IdxW'(1);

  assign st.exec_go = (item.func == FUNC_EXEC) && (status_dec == ST_OK);
  assign st.last    = last;
  assign st.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_status <= status_dec;
      is_read    <= (item.func == FUNC_READ) && (status_dec == ST_OK);
      sat_flag   <= 1'b0;
      i          <= '0;
    end else if (cmd.wr_elem) begin
      sat_flag <= sat_flag | ovf_hi | ovf_lo;
      i        <= i + IdxW'(1);
    end
  end

  always_comb begin
    re = 1'b0;
    raddr = {item.src_a_buf, i};
    if (cmd.decode) begin
      re = 1'b1;
      raddr = {item.buffer_sel, item.element_index};
    end else if (cmd.rd_a) begin
      re = 1'b1;
    end else if (cmd.rd_x) begin
      re = 1'b1;
      raddr = (item.opcode == OP_LAP) ? {item.src_a_buf, left} : {item.src_b_buf, i};
    end else if (cmd.rd_y) begin
      re = 1'b1;
      raddr = {item.src_a_buf, right};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_x) begin
      av <= rdata;
    end
    if (cmd.rd_y) begin
      xv <= rdata;
    end
  end

  assign lap_sum = OpW'(xv) - (OpW'(av) <<< 1) + OpW'($signed(rdata));

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      xop <= (item.opcode == OP_LAP) ? lap_sum : OpW'(av);
      kop <= (item.opcode == OP_MUL) ? xv : item.scalar_first;
    end
    if (cmd.mul_lo) begin
      plo <= $signed({1'b0, xop[15:0]}) * kop;
    end
    if (cmd.mul_hi) begin
      phi <= $signed(xop[OpW-1:16]) * kop;
    end
  end

  assign prod = WideW'(phi) + WideW'(plo >>> 16);

  always_comb begin
    case (item.opcode)
      OP_COPY:  w = WideW'(av);
      OP_ADD:   w = WideW'(av) + WideW'(xv);
      OP_SUB:   w = WideW'(av) - WideW'(xv);
      OP_AXPY:  w = prod + WideW'(xv);
      OP_CLAMP: begin
        if (av < item.scalar_first) begin
          w = WideW'(item.scalar_first);
        end else if (av > item.scalar_second) begin
          w = WideW'(item.scalar_second);
        end else begin
          w = WideW'(av);
        end
      end
      default:  w = prod;
    endcase
  end

  assign ovf_hi = (w > WideW'(32'sh7FFF_FFFF));
  assign ovf_lo = (w < WideW'(32'sh8000_0000));

  always_comb begin
    if (ovf_hi) begin
      elem_res = 32'h7FFF_FFFF;
    end else if (ovf_lo) begin
      elem_res = 32'h8000_0000;
    end else begin
      elem_res = w[DataWidth-1:0];
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = {item.dest_buf, i};
    wdata = elem_res;
    if (cmd.decode) begin
      we = (item.func == FUNC_LOAD) && (status_dec == ST_OK);
      waddr = {item.buffer_sel, item.element_index};
      wdata = item.load_value;
    end else if (cmd.wr_elem) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.present) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.present) begin
      m_tdata <= {4'b0, sat_flag, res_status, is_read ? rdata : 32'h0};
    end
  end

endmodule
